>>> design/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared widths, constants, side-band type and the CORDIC arctangent table
// for the accelerometer tilt angle block.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned MagW       = 17;
  localparam int unsigned AngleW     = 11;
  localparam int unsigned RadW       = 32;
  localparam int unsigned RootW      = 32;
  localparam int unsigned RemW       = 36;
  localparam int unsigned CordW      = 36;
  localparam int unsigned ZmW        = 34;
  localparam int unsigned ProdW      = 59;
  localparam int unsigned QuoInW     = 27;
  localparam int unsigned QuotW      = 10;
  localparam int unsigned ScaleMul   = 18000000;
  // ceil(2^40 / 31415); exact floor division for dividends below 2^25
  localparam int unsigned RecipMul   = 34999575;
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipW     = 53;
  localparam int unsigned AngleSat   = 900;
  localparam int unsigned SqrtSteps  = RootW;

  typedef struct packed {
    logic vld;
    logic neg;
    logic num_zero;
    logic den_zero;
  } side_t;

  // atan(2^-i) in Q32 radians
  function automatic logic signed [CordW-1:0] atan_q32(input logic [4:0] idx);
    logic signed [CordW-1:0] v;
    v = '0;
    unique case (idx)
      5'd0:    v = CordW'(64'd3373259426);
      5'd1:    v = CordW'(64'd1991351318);
      5'd2:    v = CordW'(64'd1052175346);
      5'd3:    v = CordW'(64'd534100635);
      5'd4:    v = CordW'(64'd268086748);
      5'd5:    v = CordW'(64'd134174063);
      5'd6:    v = CordW'(64'd67103403);
      5'd7:    v = CordW'(64'd33553749);
      5'd8:    v = CordW'(64'd16777131);
      5'd9:    v = CordW'(64'd8388597);
      5'd10:   v = CordW'(64'd4194303);
      default: v[6'd32 - {1'b0, idx}] = 1'b1;
    endcase
    return v;
  endfunction

endpackage

>>> design/accel_tilt_angles_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Tilt angle per axis from one accelerometer triple, three lanes in parallel.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   accel_x_i, accel_y_i, accel_z_i
//   out      source     out_valid_o / out_stall_i angle_x_o, angle_y_o, angle_z_o
//
// One triple per cycle while the output is not stalled; registers in order:
// sum of squares, square root, CORDIC, multiply, reciprocal, output.
// The whole pipeline holds while the output register is full and stalled.
// Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [atl_pkg::SampleW-1:0] accel_x_i,
  input  logic signed [atl_pkg::SampleW-1:0] accel_y_i,
  input  logic signed [atl_pkg::SampleW-1:0] accel_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [atl_pkg::AngleW-1:0]  angle_x_o,
  output logic signed [atl_pkg::AngleW-1:0]  angle_y_o,
  output logic signed [atl_pkg::AngleW-1:0]  angle_z_o
);

  logic                              en;
  logic                              out_valid_q;
  logic signed [atl_pkg::SampleW-1:0] num [3];
  logic signed [atl_pkg::SampleW-1:0] opa [3];
  logic signed [atl_pkg::SampleW-1:0] opb [3];
  logic                              lvld [3];
  logic signed [atl_pkg::AngleW-1:0] lang [3];
  logic signed [atl_pkg::AngleW-1:0] ang_q [3];

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign num[0] = accel_x_i;  assign opa[0] = accel_y_i;  assign opb[0] = accel_z_i;
  assign num[1] = accel_y_i;  assign opa[1] = accel_x_i;  assign opb[1] = accel_z_i;
  assign num[2] = accel_z_i;  assign opa[2] = accel_x_i;  assign opb[2] = accel_y_i;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    atl_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane (
      .clk_i, .rst_ni,
      .en_i   (en),
      .vld_i  (in_valid_i),
      .num_i  (num[l]),
      .a_i    (opa[l]),
      .b_i    (opb[l]),
      .vld_o  (lvld[l]),
      .angle_o(lang[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= lvld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= lang[0];
      ang_q[1] <= lang[1];
      ang_q[2] <= lang[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_x_o   = ang_q[0];
  assign angle_y_o   = ang_q[1];
  assign angle_z_o   = ang_q[2];

endmodule

>>> design/atl_isqrt.sv
// ----------------------------------------------------------------------------
// atl_isqrt
// Pipelined integer square root, one root bit per stage:
// root = floor(sqrt(rad * 2^32)).
// ----------------------------------------------------------------------------
module atl_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [atl_pkg::RadW-1:0]      rad_i,
  input  logic [atl_pkg::MagW-1:0]      mag_i,
  input  atl_pkg::side_t                side_i,
  output logic [atl_pkg::RootW-1:0]     root_o,
  output logic [atl_pkg::MagW-1:0]      mag_o,
  output atl_pkg::side_t                side_o
);

  localparam int unsigned NS = atl_pkg::SqrtSteps;

  logic [atl_pkg::RemW-1:0]  rem_q  [NS];
  logic [atl_pkg::RootW-1:0] root_q [NS];
  logic [atl_pkg::RadW-1:0]  rad_q  [NS];
  logic [atl_pkg::MagW-1:0]  mag_q  [NS];
  atl_pkg::side_t            side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [atl_pkg::RemW-1:0]  rem_in, cat, trial, rem_d;
    logic [atl_pkg::RootW-1:0] root_in, root_d;
    logic [atl_pkg::RadW-1:0]  rad_in;
    logic [atl_pkg::MagW-1:0]  mag_in;
    atl_pkg::side_t            side_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign mag_in  = mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign mag_in  = mag_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      cat   = {rem_in[atl_pkg::RemW-3:0], rad_in[atl_pkg::RadW-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (cat >= trial) begin
        rem_d  = cat - trial;
        root_d = {root_in[atl_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = cat;
        root_d = {root_in[atl_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (en_i) begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= {rad_in[atl_pkg::RadW-3:0], 2'b00};
        mag_q[s]  <= mag_in;
      end
    end
  end

  assign root_o = root_q[NS-1];
  assign mag_o  = mag_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

>>> design/atl_cordic.sv
// ----------------------------------------------------------------------------
// atl_cordic
// Pipelined vectoring CORDIC, one rotation per stage; gives the angle of
// (root, mag * 2^16) in Q32 radians.
// ----------------------------------------------------------------------------
module atl_cordic #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [atl_pkg::RootW-1:0]      root_i,
  input  logic [atl_pkg::MagW-1:0]       mag_i,
  input  atl_pkg::side_t                 side_i,
  output logic signed [atl_pkg::CordW-1:0] z_o,
  output atl_pkg::side_t                 side_o
);

  localparam int unsigned W = atl_pkg::CordW;

  logic signed [W-1:0] x_q [CORDIC_STEPS];
  logic signed [W-1:0] y_q [CORDIC_STEPS];
  logic signed [W-1:0] z_q [CORDIC_STEPS];
  atl_pkg::side_t      side_q [CORDIC_STEPS];

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    logic signed [W-1:0] x_in, y_in, z_in, x_d, y_d, z_d, dx, dy, ang;
    atl_pkg::side_t      side_in;

    if (s == 0) begin : g_first
      assign x_in    = W'(root_i);
      assign y_in    = W'({mag_i, 16'b0});
      assign z_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign z_in    = z_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      dx  = y_in >>> s;
      dy  = x_in >>> s;
      ang = atl_pkg::atan_q32(5'(s));
      if (!y_in[W-1]) begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + ang;
      end else begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (en_i) begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s] <= x_d;
        y_q[s] <= y_d;
        z_q[s] <= z_d;
      end
    end
  end

  assign z_o    = z_q[CORDIC_STEPS-1];
  assign side_o = side_q[CORDIC_STEPS-1];

endmodule

>>> design/atl_scale.sv
// ----------------------------------------------------------------------------
// atl_scale
// Radians to tenths of a degree: multiply by 18000000, drop 32 bits, then
// divide by 31415 through a reciprocal multiplication.
// ----------------------------------------------------------------------------
module atl_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic signed [atl_pkg::CordW-1:0] z_i,
  input  atl_pkg::side_t                   side_i,
  output logic [atl_pkg::QuotW-1:0]        quo_o,
  output atl_pkg::side_t                   side_o
);

  logic [atl_pkg::ZmW-1:0]    zm;
  logic [atl_pkg::ProdW-1:0]  prod_q;
  logic [atl_pkg::RecipW-1:0] recip_q;
  atl_pkg::side_t             pside_q;
  atl_pkg::side_t             side_q;

  assign zm = (!z_i[atl_pkg::CordW-1] && (z_i != '0)) ? z_i[atl_pkg::ZmW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pside_q <= '0;
      side_q  <= '0;
    end else if (en_i) begin
      pside_q <= side_i;
      side_q  <= pside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= atl_pkg::ProdW'(zm) * atl_pkg::ProdW'(atl_pkg::ScaleMul);
      recip_q <= atl_pkg::RecipW'(prod_q[atl_pkg::ProdW-1 -: atl_pkg::QuoInW]) *
                 atl_pkg::RecipW'(atl_pkg::RecipMul);
    end
  end

  assign quo_o  = recip_q[atl_pkg::RecipShift +: atl_pkg::QuotW];
  assign side_o = side_q;

endmodule

>>> design/atl_lane.sv
// ----------------------------------------------------------------------------
// atl_lane
// One axis: sum of squares of the other two axes, square root, CORDIC,
// scaling, then saturation, sign and the zero cases.
// ----------------------------------------------------------------------------
module atl_lane #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic signed [atl_pkg::SampleW-1:0] num_i,
  input  logic signed [atl_pkg::SampleW-1:0] a_i,
  input  logic signed [atl_pkg::SampleW-1:0] b_i,
  output logic                               vld_o,
  output logic signed [atl_pkg::AngleW-1:0]  angle_o
);

  logic signed [2*atl_pkg::SampleW-1:0] sq_a, sq_b;
  logic signed [atl_pkg::MagW-1:0]      num_ext;
  logic [atl_pkg::MagW-1:0]             mag_d, mag_q, sq_mag;
  logic [atl_pkg::RadW-1:0]             sum_q;
  atl_pkg::side_t                       side_d, side_q, sq_side, co_side, sc_side;
  logic [atl_pkg::RootW-1:0]            root;
  logic signed [atl_pkg::CordW-1:0]     z;
  logic [atl_pkg::QuotW-1:0]            quo, sat;
  logic signed [atl_pkg::AngleW-1:0]    mag11;

  assign sq_a    = a_i * a_i;
  assign sq_b    = b_i * b_i;
  assign num_ext = {num_i[atl_pkg::SampleW-1], num_i};
  assign mag_d   = num_i[atl_pkg::SampleW-1] ? (~num_ext + 1'b1) : num_ext;

  always_comb begin
    side_d.vld      = vld_i;
    side_d.neg      = num_i[atl_pkg::SampleW-1];
    side_d.num_zero = (num_i == '0);
    side_d.den_zero = (a_i == '0) && (b_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sq_a + sq_b;
      mag_q <= mag_d;
    end
  end

  atl_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i,
    .rad_i (sum_q), .mag_i (mag_q), .side_i (side_q),
    .root_o(root),  .mag_o (sq_mag), .side_o (sq_side)
  );

  atl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .en_i,
    .root_i(root), .mag_i(sq_mag), .side_i(sq_side),
    .z_o   (z),    .side_o(co_side)
  );

  atl_scale u_scale (
    .clk_i, .rst_ni, .en_i,
    .z_i  (z),   .side_i(co_side),
    .quo_o(quo), .side_o(sc_side)
  );

  assign sat   = (quo > atl_pkg::QuotW'(atl_pkg::AngleSat)) ?
                 atl_pkg::QuotW'(atl_pkg::AngleSat) : quo;
  assign mag11 = atl_pkg::AngleW'(sat);
  assign vld_o = sc_side.vld;

  always_comb begin
    priority if (sc_side.num_zero) begin
      angle_o = '0;
    end else if (sc_side.den_zero) begin
      angle_o = sc_side.neg ? -atl_pkg::AngleW'(atl_pkg::AngleSat)
                            :  atl_pkg::AngleW'(atl_pkg::AngleSat);
    end else begin
      angle_o = sc_side.neg ? -mag11 : mag11;
    end
  end

endmodule
